// ===== sv/rbs_pkg.sv =====
// Shared widths, constants and the sideband type for the ray/box slab block.
// No dependencies; imported by rbs_div and ray_box_slab_intersect.
`default_nettype none
package rbs_pkg;
    localparam int IN_W    = 32;            // Q16.16 coordinate width
    localparam int DIFF_W  = IN_W + 1;      // exact difference of two coordinates
    localparam int MAG_W   = IN_W;          // magnitude of a difference
    localparam int FRAC_B  = 16;            // fraction bits of Q16.16
    localparam int NUM_W   = MAG_W + FRAC_B; // scaled dividend, quotient bits
    localparam int T_W     = NUM_W + 3;     // signed slab parameter with room for sentinels
    localparam int DIV_LAT = NUM_W + 2;     // load stage + one stage per bit + sign fixup

    localparam logic [MAG_W-1:0] PARALLEL_LIMIT = MAG_W'(1);

    localparam logic signed [T_W-1:0] ENTRY_NONE = -(T_W'(1) <<< (T_W - 2));
    localparam logic signed [T_W-1:0] EXIT_NONE  =  (T_W'(1) <<< (T_W - 2));

    localparam logic signed [1:0] NORM_ZERO = 2'sd0;
    localparam logic signed [1:0] NORM_POS  = 2'sd1;
    localparam logic signed [1:0] NORM_NEG  = -2'sd1;

    typedef struct packed {
        logic              valid;
        logic              par_x;
        logic              par_y;
        logic              par_miss;
        logic [IN_W-1:0]   limit;
    } side_t;
endpackage
`default_nettype wire

// ===== sv/rbs_div.sv =====
// Pipelined signed floor division floor(num * 2^16 / den), one quotient bit per stage.
// Depends on rbs_pkg.
`default_nettype none
module rbs_div (
    input  wire                                 aclk,
    input  wire                                 en,
    input  wire  logic signed [rbs_pkg::DIFF_W-1:0] num,
    input  wire  logic signed [rbs_pkg::DIFF_W-1:0] den,
    output logic signed [rbs_pkg::T_W-1:0]      quo
);
    import rbs_pkg::*;

    logic [MAG_W-1:0] rem_reg [0:NUM_W];
    logic [NUM_W-1:0] w_reg   [0:NUM_W];
    logic [MAG_W-1:0] d_reg   [0:NUM_W];
    logic             neg_reg [0:NUM_W];

    logic [DIFF_W-1:0] num_abs, den_abs;
    assign num_abs = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    assign den_abs = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            w_reg[0]   <= {num_abs[MAG_W-1:0], FRAC_B'(0)};
            d_reg[0]   <= den_abs[MAG_W-1:0];
            neg_reg[0] <= num[DIFF_W-1] ^ den[DIFF_W-1];
        end
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
        logic [MAG_W:0]   cat;
        logic [MAG_W+1:0] trial;
        logic             ge;
        assign cat   = {rem_reg[k-1], w_reg[k-1][NUM_W-1]};
        assign trial = {1'b0, cat} - {2'b00, d_reg[k-1]};
        assign ge    = ~trial[MAG_W+1];
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? trial[MAG_W-1:0] : cat[MAG_W-1:0];
                w_reg[k]   <= {w_reg[k-1][NUM_W-2:0], ge};
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    logic [T_W-1:0] q_ext, q_up;
    assign q_ext = {{(T_W-NUM_W){1'b0}}, w_reg[NUM_W]};
    assign q_up  = q_ext + T_W'(rem_reg[NUM_W] != '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            quo <= neg_reg[NUM_W] ? -$signed(q_up) : $signed(q_ext);
        end
    end
endmodule
`default_nettype wire

// ===== sv/ray_box_slab_intersect.sv =====
// Top level: 2D segment versus axis-aligned box, slab method, Q16.16.
// Depends on rbs_pkg and rbs_div.
//
// Usage:
//   Input channel s_*: one beat is a query (box corners, segment start and end,
//   fraction_limit). Output channel m_*: one result beat per query, in order:
//   hit, hit_fraction (Q16.16) and the entry face normal, all zero on a miss.
//   Throughput: one query per cycle when m_ready stays high.
//   Pipeline, from input beat to result beat: one input
//   stage, the four bit-serial-in-space dividers (one quotient bit per stage,
//   48 stages plus load and sign fixup), then swap, combine and bound stages.
//   The whole pipeline advances as one: when m_valid is high and m_ready low,
//   every stage holds, and s_ready drops in the same cycle. Nothing is lost or
//   repeated; bubbles keep their place.
//   Reset (aresetn low, synchronous) clears all valid bits; the datapath
//   registers are not reset.
`default_nettype none
module ray_box_slab_intersect (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  logic signed [31:0]      s_lower_x,
    input  wire  logic signed [31:0]      s_lower_y,
    input  wire  logic signed [31:0]      s_upper_x,
    input  wire  logic signed [31:0]      s_upper_y,
    input  wire  logic signed [31:0]      s_start_x,
    input  wire  logic signed [31:0]      s_start_y,
    input  wire  logic signed [31:0]      s_end_x,
    input  wire  logic signed [31:0]      s_end_y,
    input  wire  logic [31:0]             s_fraction_limit,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_hit,
    output logic [31:0]                   m_hit_fraction,
    output logic signed [1:0]             m_normal_x,
    output logic signed [1:0]             m_normal_y
);
    import rbs_pkg::*;

    // single advance for every stage
    logic en;
    assign en      = ~m_valid | m_ready;
    assign s_ready = en;

    // ---- stage A: differences and parallel-axis start test ----
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] a_nlo_x_reg, a_nhi_x_reg, a_nlo_y_reg, a_nhi_y_reg;
    logic signed [DIFF_W-1:0] a_d_x_reg, a_d_y_reg;
    logic                     a_out_x_reg, a_out_y_reg;
    logic [IN_W-1:0]          a_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_nlo_x_reg <= DIFF_W'(s_lower_x) - DIFF_W'(s_start_x);
            a_nhi_x_reg <= DIFF_W'(s_upper_x) - DIFF_W'(s_start_x);
            a_nlo_y_reg <= DIFF_W'(s_lower_y) - DIFF_W'(s_start_y);
            a_nhi_y_reg <= DIFF_W'(s_upper_y) - DIFF_W'(s_start_y);
            a_d_x_reg   <= DIFF_W'(s_end_x) - DIFF_W'(s_start_x);
            a_d_y_reg   <= DIFF_W'(s_end_y) - DIFF_W'(s_start_y);
            a_out_x_reg <= (s_start_x < s_lower_x) || (s_upper_x < s_start_x);
            a_out_y_reg <= (s_start_y < s_lower_y) || (s_upper_y < s_start_y);
            a_limit_reg <= s_fraction_limit;
        end
    end

    // parallel test on the direction magnitude (zero is always parallel)
    logic [DIFF_W-1:0] ad_x, ad_y;
    logic              par_x, par_y;
    assign ad_x  = a_d_x_reg[DIFF_W-1] ? DIFF_W'(-a_d_x_reg) : DIFF_W'(a_d_x_reg);
    assign ad_y  = a_d_y_reg[DIFF_W-1] ? DIFF_W'(-a_d_y_reg) : DIFF_W'(a_d_y_reg);
    assign par_x = (ad_x == '0) || (ad_x < DIFF_W'(PARALLEL_LIMIT));
    assign par_y = (ad_y == '0) || (ad_y < DIFF_W'(PARALLEL_LIMIT));

    // ---- divider stages, sideband rides a matching delay line ----
    logic signed [T_W-1:0] t_lo_x, t_hi_x, t_lo_y, t_hi_y;

    rbs_div u_div_lo_x (.aclk(aclk), .en(en), .num(a_nlo_x_reg), .den(a_d_x_reg), .quo(t_lo_x));
    rbs_div u_div_hi_x (.aclk(aclk), .en(en), .num(a_nhi_x_reg), .den(a_d_x_reg), .quo(t_hi_x));
    rbs_div u_div_lo_y (.aclk(aclk), .en(en), .num(a_nlo_y_reg), .den(a_d_y_reg), .quo(t_lo_y));
    rbs_div u_div_hi_y (.aclk(aclk), .en(en), .num(a_nhi_y_reg), .den(a_d_y_reg), .quo(t_hi_y));

    side_t side_reg [0:DIV_LAT-1];
    side_t side_in;
    always_comb begin
        side_in.valid    = a_valid_reg;
        side_in.par_x    = par_x;
        side_in.par_y    = par_y;
        side_in.par_miss = (par_x & a_out_x_reg) | (par_y & a_out_y_reg);
        side_in.limit    = a_limit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) side_reg[i].valid <= 1'b0;
        end else if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DIV_LAT; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    side_t side_d;
    assign side_d = side_reg[DIV_LAT-1];

    // ---- stage C: order entry/exit per axis ----
    logic                  c_valid_reg;
    side_t                 c_side_reg;
    logic signed [T_W-1:0] c_en_x_reg, c_ex_x_reg, c_en_y_reg, c_ex_y_reg;
    logic                  c_pos_x_reg, c_pos_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= side_d.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg  <= side_d;
            c_pos_x_reg <= t_lo_x > t_hi_x;
            c_en_x_reg  <= (t_lo_x > t_hi_x) ? t_hi_x : t_lo_x;
            c_ex_x_reg  <= (t_lo_x > t_hi_x) ? t_lo_x : t_hi_x;
            c_pos_y_reg <= t_lo_y > t_hi_y;
            c_en_y_reg  <= (t_lo_y > t_hi_y) ? t_hi_y : t_lo_y;
            c_ex_y_reg  <= (t_lo_y > t_hi_y) ? t_lo_y : t_hi_y;
        end
    end

    // ---- stage D: merge axes; x keeps ties ----
    logic                  d_valid_reg;
    logic                  d_miss_reg;
    logic [IN_W-1:0]       d_limit_reg;
    logic signed [T_W-1:0] d_enter_reg, d_exit_reg;
    logic signed [1:0]     d_nx_reg, d_ny_reg;

    logic signed [T_W-1:0] ex_enter, ex_exit, y_enter, y_exit;
    logic                  take_y;
    always_comb begin
        ex_enter = c_side_reg.par_x ? ENTRY_NONE : c_en_x_reg;
        ex_exit  = c_side_reg.par_x ? EXIT_NONE  : c_ex_x_reg;
        y_enter  = c_side_reg.par_y ? ENTRY_NONE : c_en_y_reg;
        y_exit   = c_side_reg.par_y ? EXIT_NONE  : c_ex_y_reg;
        take_y   = ~c_side_reg.par_y && (c_en_y_reg > ex_enter);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_miss_reg  <= c_side_reg.par_miss;
            d_limit_reg <= c_side_reg.limit;
            d_enter_reg <= take_y ? y_enter : ex_enter;
            d_exit_reg  <= (y_exit < ex_exit) ? y_exit : ex_exit;
            if (take_y) begin
                d_nx_reg <= NORM_ZERO;
                d_ny_reg <= c_pos_y_reg ? NORM_POS : NORM_NEG;
            end else if (!c_side_reg.par_x) begin
                d_nx_reg <= c_pos_x_reg ? NORM_POS : NORM_NEG;
                d_ny_reg <= NORM_ZERO;
            end else begin
                d_nx_reg <= NORM_ZERO;
                d_ny_reg <= NORM_ZERO;
            end
        end
    end

    // ---- stage E: interval and limit checks, output register ----
    logic hit_c;
    assign hit_c = ~d_miss_reg
                && !(d_enter_reg > d_exit_reg)
                && !d_enter_reg[T_W-1]
                && !($signed({1'b0, d_limit_reg}) < d_enter_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit          <= hit_c;
            m_hit_fraction <= hit_c ? d_enter_reg[IN_W-1:0] : '0;
            m_normal_x     <= hit_c ? d_nx_reg : NORM_ZERO;
            m_normal_y     <= hit_c ? d_ny_reg : NORM_ZERO;
        end
    end

`ifndef ASSERT_OFF
    a_hit_one_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> ((m_normal_x != NORM_ZERO) != (m_normal_y != NORM_ZERO)))
        else $error("hit without exactly one normal axis");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_hit_fraction == '0 && m_normal_x == NORM_ZERO
                               && m_normal_y == NORM_ZERO))
        else $error("miss result not zeroed");
    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipeline stalled");
    a_stall_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_fraction))
        else $error("result dropped during stall");
`endif
endmodule
`default_nettype wire
